### sv/hidsr_pkg.sv
// ----------------------------------------------------------------------------
// hidsr_pkg
// Types and codes shared by the HID setup request handler and its decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hidsr_pkg;

    // bmRequestType bits 6:5
    typedef enum logic [1:0] {
        KIND_STANDARD = 2'd0,
        KIND_CLASS    = 2'd1,
        KIND_VENDOR   = 2'd2,
        KIND_RESERVED = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        RESP_ACK   = 2'd0,
        RESP_SEND  = 2'd1,
        RESP_STALL = 2'd2
    } resp_t;

    typedef enum logic [2:0] {
        SRC_NONE     = 3'd0,
        SRC_PROTOCOL = 3'd1,
        SRC_IDLE     = 3'd2,
        SRC_ALT      = 3'd3,
        SRC_STATUS   = 3'd4,
        SRC_REPORT   = 3'd5,
        SRC_HIDDESC  = 3'd6
    } src_t;

    // class request codes
    localparam logic [7:0] HID_SET_PROTOCOL = 8'h0B;
    localparam logic [7:0] HID_GET_PROTOCOL = 8'h03;
    localparam logic [7:0] HID_SET_IDLE     = 8'h0A;
    localparam logic [7:0] HID_GET_IDLE     = 8'h02;

    // standard request codes
    localparam logic [7:0] STD_GET_STATUS     = 8'h00;
    localparam logic [7:0] STD_CLEAR_FEATURE  = 8'h01;
    localparam logic [7:0] STD_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] STD_GET_INTERFACE  = 8'h0A;
    localparam logic [7:0] STD_SET_INTERFACE  = 8'h0B;

    // descriptor types (wValue high byte)
    localparam logic [7:0] DESC_REPORT = 8'h22;
    localparam logic [7:0] DESC_HID    = 8'h21;

    localparam int          LEN_W            = 10;
    localparam logic [9:0]  HID_DESC_BYTES   = 10'd9;
    localparam logic [9:0]  STATUS_BYTES     = 10'd2;
    localparam logic [9:0]  ONE_BYTE         = 10'd1;
    localparam logic [9:0]  REPORT_LEN_RESET = 10'd74;

    // APB register map
    localparam int          PADDR_W        = 3;
    localparam logic        REG_REPORT_LEN = 1'b0;

    typedef struct packed {
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
        logic        device_configured;
    } req_t;

    typedef struct packed {
        logic [1:0]       response;
        logic [2:0]       data_source;
        logic [LEN_W-1:0] send_length;
        logic [7:0]       send_value;
    } rsp_t;

    typedef struct packed {
        logic [7:0] protocol_mode;
        logic [7:0] idle_rate;
        logic [7:0] alternate_setting;
    } hid_state_t;

    // state writes raised by one request
    typedef struct packed {
        logic       set_protocol;
        logic       set_idle;
        logic       set_alt;
        logic [7:0] value;
    } state_upd_t;

endpackage

`default_nettype wire

### sv/hidsr_decode.sv
// ----------------------------------------------------------------------------
// hidsr_decode
// Decodes one setup request against the current HID state into a result and
// the state writes it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module hidsr_decode (
    input  wire hidsr_pkg::req_t       req,
    input  wire hidsr_pkg::hid_state_t st,
    input  wire logic [9:0]            report_len,
    output hidsr_pkg::rsp_t            rsp,
    output hidsr_pkg::state_upd_t      upd
);
    import hidsr_pkg::*;

    req_kind_t  kind;
    logic [7:0] desc_type;
    logic [9:0] report_clamp;
    logic [9:0] hid_clamp;

    assign kind      = req_kind_t'(req.request_type[6:5]);
    assign desc_type = req.request_value[15:8];

    // asked is 16 bits; the clamp result never exceeds the 10-bit avail
    assign report_clamp = ({6'd0, report_len} > req.request_length) ?
                          req.request_length[9:0] : report_len;
    assign hid_clamp    = ({6'd0, HID_DESC_BYTES} > req.request_length) ?
                          req.request_length[9:0] : HID_DESC_BYTES;

    always_comb
    begin
        rsp = '{response: RESP_STALL, data_source: SRC_NONE,
                send_length: '0, send_value: '0};
        upd = '{set_protocol: 1'b0, set_idle: 1'b0, set_alt: 1'b0,
                value: req.request_value[7:0]};

        case (kind)
            KIND_CLASS:
            begin
                case (req.request_code)
                    HID_SET_PROTOCOL:
                    begin
                        upd.set_protocol = 1'b1;
                        rsp.response     = RESP_ACK;
                    end
                    HID_GET_PROTOCOL:
                    begin
                        rsp = '{response: RESP_SEND, data_source: SRC_PROTOCOL,
                                send_length: ONE_BYTE, send_value: st.protocol_mode};
                    end
                    HID_SET_IDLE:
                    begin
                        upd.set_idle = 1'b1;
                        upd.value    = req.request_value[15:8];
                        rsp.response = RESP_ACK;
                    end
                    HID_GET_IDLE:
                    begin
                        rsp = '{response: RESP_SEND, data_source: SRC_IDLE,
                                send_length: ONE_BYTE, send_value: st.idle_rate};
                    end
                    default: ;
                endcase
            end
            KIND_STANDARD:
            begin
                case (req.request_code)
                    STD_GET_STATUS:
                    begin
                        if (req.device_configured)
                        begin
                            rsp = '{response: RESP_SEND, data_source: SRC_STATUS,
                                    send_length: STATUS_BYTES, send_value: '0};
                        end
                    end
                    STD_GET_DESCRIPTOR:
                    begin
                        if (desc_type == DESC_REPORT)
                        begin
                            rsp = '{response: RESP_SEND, data_source: SRC_REPORT,
                                    send_length: report_clamp, send_value: '0};
                        end
                        else if (desc_type == DESC_HID)
                        begin
                            rsp = '{response: RESP_SEND, data_source: SRC_HIDDESC,
                                    send_length: hid_clamp, send_value: '0};
                        end
                    end
                    STD_GET_INTERFACE:
                    begin
                        if (req.device_configured)
                        begin
                            rsp = '{response: RESP_SEND, data_source: SRC_ALT,
                                    send_length: ONE_BYTE,
                                    send_value: st.alternate_setting};
                        end
                    end
                    STD_SET_INTERFACE:
                    begin
                        if (req.device_configured)
                        begin
                            upd.set_alt  = 1'b1;
                            rsp.response = RESP_ACK;
                        end
                    end
                    STD_CLEAR_FEATURE:
                    begin
                        rsp.response = RESP_ACK;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### sv/hid_setup_request_handler.sv
// ----------------------------------------------------------------------------
// hid_setup_request_handler
// HID class and standard setup request decode for control endpoint zero.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req/req_valid/req_ready; each request yields exactly
//   one result on rsp/rsp_valid/rsp_ready (acknowledge, send data or stall,
//   with data source, length and byte value).
//   A request is captured into an input register, decoded combinationally and
//   written to the result register, which drives rsp_valid. One request per
//   cycle is sustained while rsp_ready stays high; the input register
//   and the result register decouple the two sides.
//   Protocol mode, idle rate and alternate setting are updated as a request
//   moves into the result register, so the next request sees them at once.
//   When the receiver stalls, the result holds and one further request is
//   held in the input register; req_ready then drops.
//   The APB port holds the report descriptor length at address 0.
//   Reset clears the state to zero, the descriptor length to 74, and
//   empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_setup_request_handler (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire hidsr_pkg::req_t                  req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output hidsr_pkg::rsp_t                       rsp,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [hidsr_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import hidsr_pkg::*;

    logic       in_vld_reg;
    req_t       in_req_reg;
    logic       out_vld_reg;
    rsp_t       out_rsp_reg;
    hid_state_t st_reg;
    hid_state_t st_next;
    logic [9:0] report_len_reg;

    rsp_t       dec_rsp;
    state_upd_t dec_upd;
    logic       advance;
    logic       cfg_wr;

    hidsr_decode u_decode (
        .req        (in_req_reg),
        .st         (st_reg),
        .report_len (report_len_reg),
        .rsp        (dec_rsp),
        .upd        (dec_upd)
    );

    assign advance   = in_vld_reg && (!out_vld_reg || rsp_ready);
    assign req_ready = !in_vld_reg || advance;
    assign rsp_valid = out_vld_reg;
    assign rsp       = out_rsp_reg;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_REPORT_LEN);
    assign prdata = (paddr[2] == REG_REPORT_LEN) ? {22'd0, report_len_reg} : 32'd0;

    always_comb
    begin
        st_next = st_reg;
        if (advance)
        begin
            if (dec_upd.set_protocol)
                st_next.protocol_mode = dec_upd.value;
            if (dec_upd.set_idle)
                st_next.idle_rate = dec_upd.value;
            if (dec_upd.set_alt)
                st_next.alternate_setting = dec_upd.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            st_reg         <= '0;
            report_len_reg <= REPORT_LEN_RESET;
        end
        else
        begin
            if (req_ready)
                in_vld_reg <= req_valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (rsp_ready)
                out_vld_reg <= 1'b0;
            st_reg <= st_next;
            if (cfg_wr)
                report_len_reg <= pwdata[9:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            in_req_reg <= req;
        if (advance)
            out_rsp_reg <= dec_rsp;
    end

    // a held request stays put while the result ahead of it is stalled
    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_req_reg)))
        else $error("held request lost while result stalled");

    a_stall_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_rsp_reg.response != RESP_SEND) |->
        (out_rsp_reg.data_source == SRC_NONE && out_rsp_reg.send_length == '0
         && out_rsp_reg.send_value == '0))
        else $error("non-data result carries data fields");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st_reg))
        else $error("HID state changed without a request moving");

    a_send_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_rsp_reg.response == RESP_SEND &&
         (out_rsp_reg.data_source == SRC_PROTOCOL || out_rsp_reg.data_source == SRC_IDLE
          || out_rsp_reg.data_source == SRC_ALT)) |-> out_rsp_reg.send_length == ONE_BYTE)
        else $error("one-byte reply with wrong length");

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hid_setup_request_handler. Requests go in through
// a valid/ready channel with random gaps. A small class mirrors the protocol,
// idle and alternate-setting state and predicts each reply. Replies are
// matched in order against those predictions. The descriptor length register
// is rewritten over APB between phases, when the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import hidsr_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 180;
    localparam logic [PADDR_W-1:0] ADDR_REPORT_LEN = PADDR_W'(4 * REG_REPORT_LEN);

    // Mirrors the handler state and predicts one reply per request
    class setup_reply_board;
        logic [7:0] protocol_mode;
        logic [7:0] idle_rate;
        logic [7:0] alternate_setting;
        logic [9:0] report_len;
        rsp_t       replies_due[$];
        int         errors;

        function new();
            protocol_mode     = '0;
            idle_rate         = '0;
            alternate_setting = '0;
            report_len        = REPORT_LEN_RESET;
            errors            = 0;
        endfunction

        function void set_report_len(logic [31:0] v);
            report_len = v[9:0];
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function rsp_t data_reply(src_t src, logic [9:0] len, logic [7:0] val);
            rsp_t e;
            e.response    = RESP_SEND;
            e.data_source = src;
            e.send_length = len;
            e.send_value  = val;
            return e;
        endfunction

        function logic [9:0] clamp(logic [9:0] avail, logic [15:0] asked);
            return (asked < {6'd0, avail}) ? asked[9:0] : avail;
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            e = '0;
            e.response = RESP_STALL;
            case (req_kind_t'(r.request_type[6:5]))
                KIND_CLASS:
                    case (r.request_code)
                        HID_SET_PROTOCOL:
                        begin
                            protocol_mode = r.request_value[7:0];
                            e.response = RESP_ACK;
                        end
                        HID_GET_PROTOCOL: e = data_reply(SRC_PROTOCOL, ONE_BYTE, protocol_mode);
                        HID_SET_IDLE:
                        begin
                            idle_rate = r.request_value[15:8];
                            e.response = RESP_ACK;
                        end
                        HID_GET_IDLE: e = data_reply(SRC_IDLE, ONE_BYTE, idle_rate);
                        default: ;
                    endcase
                KIND_STANDARD:
                    case (r.request_code)
                        STD_GET_STATUS:
                            if (r.device_configured)
                                e = data_reply(SRC_STATUS, STATUS_BYTES, 8'd0);
                        STD_GET_DESCRIPTOR:
                            if (r.request_value[15:8] == DESC_REPORT)
                                e = data_reply(SRC_REPORT,
                                               clamp(report_len, r.request_length), 8'd0);
                            else if (r.request_value[15:8] == DESC_HID)
                                e = data_reply(SRC_HIDDESC,
                                               clamp(HID_DESC_BYTES, r.request_length), 8'd0);
                        STD_GET_INTERFACE:
                            if (r.device_configured)
                                e = data_reply(SRC_ALT, ONE_BYTE, alternate_setting);
                        STD_SET_INTERFACE:
                            if (r.device_configured)
                            begin
                                alternate_setting = r.request_value[7:0];
                                e.response = RESP_ACK;
                            end
                        STD_CLEAR_FEATURE: e.response = RESP_ACK;
                        default: ;
                    endcase
                default: ;
            endcase
            replies_due.push_back(e);
        endfunction

        function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
            if (act !== exp)
            begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, exp, act);
            end
        endfunction

        function void check_reply(rsp_t got);
            rsp_t e;
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply, expected none actual %h", $time, got);
                return;
            end
            e = replies_due.pop_front();
            compare_field("response", 16'(e.response), 16'(got.response));
            compare_field("data_source", 16'(e.data_source), 16'(got.data_source));
            compare_field("send_length", 16'(e.send_length), 16'(got.send_length));
            compare_field("send_value", 16'(e.send_value), 16'(got.send_value));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    setup_reply_board board;
    int cycles;
    bit burst;          // no idling on either side while set
    bit hold_request;   // receiver holds off once for a long stretch

    hid_setup_request_handler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            board.check_reply(rsp);

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 10);
    endfunction

    // Receiver: random stall per reply, one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int stall;
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = draw_gap();
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    // valid is left high on return so a back-to-back request needs no toggle
    task automatic send_request(req_t r);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        board.note_request(r);
    endtask

    task automatic quiet_and_drain();
        req_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_report_len(logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_REPORT_LEN;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_report_len(v);
    endtask

    function automatic req_t setup_packet(logic [7:0] rtype, logic [7:0] code,
                                          logic [15:0] value, logic [15:0] len,
                                          logic cfg);
        req_t r;
        r.request_type      = rtype;
        r.request_code      = code;
        r.request_value     = value;
        r.request_length    = len;
        r.device_configured = cfg;
        return r;
    endfunction

    function automatic logic [7:0] type_byte(req_kind_t kind);
        logic [7:0] t;
        t      = 8'($urandom);
        t[6:5] = kind;
        return t;
    endfunction

    // Mostly well-formed requests with random content, some noise
    function automatic req_t random_request(logic [9:0] cur_len);
        req_t r;
        int pick;
        logic [7:0] std_codes [5];
        logic [7:0] cls_codes [4];
        std_codes = '{STD_GET_STATUS, STD_CLEAR_FEATURE, STD_GET_DESCRIPTOR,
                      STD_GET_INTERFACE, STD_SET_INTERFACE};
        cls_codes = '{HID_SET_PROTOCOL, HID_GET_PROTOCOL, HID_SET_IDLE, HID_GET_IDLE};
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.request_type = type_byte(KIND_STANDARD);
        else if (pick < 85)
            r.request_type = type_byte(KIND_CLASS);
        else if (pick < 93)
            r.request_type = type_byte(KIND_VENDOR);
        else
            r.request_type = type_byte(KIND_RESERVED);
        if ($urandom_range(0, 9) == 0)
            r.request_code = 8'($urandom);
        else if ($urandom_range(0, 1) == 0)
            r.request_code = std_codes[$urandom_range(0, 4)];
        else
            r.request_code = cls_codes[$urandom_range(0, 3)];
        r.request_value = 16'($urandom);
        if (r.request_code == STD_GET_DESCRIPTOR && $urandom_range(0, 9) < 8)
            r.request_value[15:8] = $urandom_range(0, 1) ? DESC_REPORT : DESC_HID;
        case ($urandom_range(0, 5))
            0: r.request_length = '0;
            1: r.request_length = 16'($urandom_range(0, 16));
            2: r.request_length = 16'($urandom_range(0, 1100));
            3: r.request_length = 16'($urandom);
            4: r.request_length = 16'hFFFF;
            default: r.request_length = 16'(cur_len) + 16'($urandom_range(0, 2)) - 16'd1;
        endcase
        r.device_configured = ($urandom_range(0, 4) != 0);
        return r;
    endfunction

    initial
    begin
        req_t directed[$];
        logic [31:0] lengths [8];
        logic [7:0] std_in;
        logic [7:0] std_out;
        logic [7:0] cls;
        board        = new();
        cycles       = 0;
        burst        = 1'b0;
        hold_request = 1'b0;
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_ready    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        std_in  = {1'b1, KIND_STANDARD, 5'd1};
        std_out = {1'b0, KIND_STANDARD, 5'd1};
        cls     = {1'b1, KIND_CLASS, 5'd1};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reads before any write see the reset state
        directed.push_back(setup_packet(cls, HID_GET_PROTOCOL, 16'h0000, 16'd1, 1'b0));
        directed.push_back(setup_packet(cls, HID_SET_PROTOCOL, 16'h00FF, 16'd0, 1'b0));
        directed.push_back(setup_packet(cls, HID_GET_PROTOCOL, 16'hFFFF, 16'hFFFF, 1'b1));
        directed.push_back(setup_packet(cls, HID_SET_IDLE, 16'hFF00, 16'd0, 1'b1));
        directed.push_back(setup_packet(cls, HID_GET_IDLE, 16'h0000, 16'd1, 1'b0));
        directed.push_back(setup_packet(cls, HID_SET_IDLE, 16'h00FF, 16'd0, 1'b0));
        directed.push_back(setup_packet(cls, HID_GET_IDLE, 16'h0000, 16'd1, 1'b1));
        directed.push_back(setup_packet(cls, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
        directed.push_back(setup_packet(std_in, STD_GET_STATUS, 16'h0000, 16'd2, 1'b1));
        directed.push_back(setup_packet(std_in, STD_GET_STATUS, 16'h0000, 16'd2, 1'b0));
        directed.push_back(setup_packet(std_in, STD_GET_DESCRIPTOR, {DESC_REPORT, 8'h00},
                                        16'd0, 1'b0));
        directed.push_back(setup_packet(std_in, STD_GET_DESCRIPTOR, {DESC_REPORT, 8'hFF},
                                        16'hFFFF, 1'b1));
        directed.push_back(setup_packet(std_in, STD_GET_DESCRIPTOR, {DESC_REPORT, 8'h00},
                                        16'd73, 1'b1));
        directed.push_back(setup_packet(std_in, STD_GET_DESCRIPTOR, {DESC_HID, 8'h00},
                                        16'd0, 1'b1));
        directed.push_back(setup_packet(std_in, STD_GET_DESCRIPTOR, {DESC_HID, 8'h00},
                                        16'd5, 1'b1));
        directed.push_back(setup_packet(std_in, STD_GET_DESCRIPTOR, {DESC_HID, 8'h00},
                                        16'hFFFF, 1'b0));
        directed.push_back(setup_packet(std_in, STD_GET_DESCRIPTOR, 16'h2300, 16'd64, 1'b1));
        directed.push_back(setup_packet(std_out, STD_SET_INTERFACE, 16'h00FF, 16'd0, 1'b0));
        directed.push_back(setup_packet(std_in, STD_GET_INTERFACE, 16'h0000, 16'd1, 1'b1));
        directed.push_back(setup_packet(std_out, STD_SET_INTERFACE, 16'hFFFF, 16'd0, 1'b1));
        directed.push_back(setup_packet(std_in, STD_GET_INTERFACE, 16'h0000, 16'd1, 1'b1));
        directed.push_back(setup_packet(std_in, STD_GET_INTERFACE, 16'h0000, 16'd1, 1'b0));
        directed.push_back(setup_packet(std_out, STD_CLEAR_FEATURE, 16'h0000, 16'd0, 1'b0));
        directed.push_back(setup_packet(std_in, 8'hFF, 16'h0000, 16'd0, 1'b1));
        directed.push_back(setup_packet({1'b1, KIND_VENDOR, 5'd0}, HID_GET_PROTOCOL,
                                        16'h0000, 16'd1, 1'b1));
        directed.push_back(setup_packet(8'hFF, STD_GET_STATUS, 16'h0000, 16'd2, 1'b1));
        foreach (directed[i])
            send_request(directed[i]);

        // descriptor length settings, extremes among them
        lengths = '{32'd0, 32'hFFFF_FFFF, 32'd9, 32'd8, 32'd10, $urandom, 32'd1, 32'd74};
        foreach (lengths[p])
        begin
            quiet_and_drain();
            write_report_len(lengths[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 0 && i == 40)
                begin
                    // fill both stages and stall the request side
                    hold_request = 1'b1;
                    burst = 1'b1;
                end
                if (i == 70 || i == 160)
                    burst = 1'b0;
                if (i == 130)
                    burst = 1'b1;
                if (p == 2 && i == 90)
                    quiet_and_drain();
                send_request(random_request(board.report_len));
            end
        end

        quiet_and_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

### hid_setup_request_handler.f
sv/hidsr_pkg.sv
sv/hidsr_decode.sv
sv/hid_setup_request_handler.sv
sim/testbench.sv
